// ----- rtl/dmxpm_pkg.sv -----
// dmxpm_pkg: shared types and constants for the priority merge table
// word layouts on both channels, request codes, controller states and
// controller/datapath command and status groups; depends on nothing
package dmxpm_pkg;

  // default table geometry
  localparam int NUM_UNIVERSES_DEF         = 16;
  localparam int CHANNELS_PER_UNIVERSE_DEF = 512;

  // field widths
  localparam int REQ_W  = 2;
  localparam int UNI_W  = 4;
  localparam int CHAN_W = 10;
  localparam int LVL_W  = 8;
  localparam int PRIO_W = 8;

  // universes reachable through the index field
  localparam int UNI_SPACE = 1 << UNI_W;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SINGLE = 2'd0,
    REQ_FRAME  = 2'd1,
    REQ_READ   = 2'd2
  } req_code_t;

  // request word
  typedef struct packed {
    req_code_t             req_type;
    logic [UNI_W-1:0]      universe_index;
    logic [CHAN_W-1:0]     channel_number;
    logic [LVL_W-1:0]      level;
    logic [PRIO_W-1:0]     source_priority;
    logic                  frame_last;
  } req_word_t;

  // response word
  typedef struct packed {
    logic                  written;
    logic [LVL_W-1:0]      read_level;
    logic [PRIO_W-1:0]     read_priority;
    logic                  universe_active;
  } rsp_word_t;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MERGE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_hold;
  } dp_stat_t;

endpackage

// ----- rtl/dmxpm_ram.sv -----
// dmxpm_ram: generic simple dual-port ram, one write and one registered read
// per cycle; no dependencies
module dmxpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dmxpm_ctrl.sv -----
// dmxpm_ctrl: controller state machine for the priority merge table
// sequences the clearing pass, request intake and merge commit; uses dmxpm_pkg
module dmxpm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  dmxpm_pkg::dp_stat_t stat,
  output dmxpm_pkg::dp_cmd_t  cmd
);
  import dmxpm_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (!stat.out_hold) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        req_stall     = 1'b0;
        cmd.load_item = req_valid;
      end
      ST_MERGE: begin
        cmd.commit = !stat.out_hold;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // a taken word always moves on to the merge
  a_load_to_merge: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> state == ST_MERGE)
    else $error("accepted word did not enter merge");

  // merge never commits into a held response
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !stat.out_hold)
    else $error("commit while response held");

  // no intake during the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> req_stall && !cmd.load_item)
    else $error("intake during clearing pass");

endmodule

// ----- rtl/dmxpm_datapath.sv -----
// dmxpm_datapath: entry table, active marks, item and response registers
// compares priority and writes back on command; uses dmxpm_pkg and dmxpm_ram
module dmxpm_datapath #(
  parameter int NUM_UNIVERSES         = dmxpm_pkg::NUM_UNIVERSES_DEF,
  parameter int CHANNELS_PER_UNIVERSE = dmxpm_pkg::CHANNELS_PER_UNIVERSE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dmxpm_pkg::dp_cmd_t   cmd,
  output dmxpm_pkg::dp_stat_t  stat,
  input  dmxpm_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output dmxpm_pkg::rsp_word_t rsp
);
  import dmxpm_pkg::*;

  localparam int DEPTH  = NUM_UNIVERSES * CHANNELS_PER_UNIVERSE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W  = LVL_W + PRIO_W;

  // item register
  req_word_t         item;
  logic              item_uni_ok;
  logic              item_chan_ok;
  logic [ADDR_W-1:0] item_addr;

  // clearing pass counter
  logic [ADDR_W-1:0] clr_cnt;

  // active marks, one per reachable universe
  logic [UNI_SPACE-1:0] marks;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  // incoming address decode
  logic [31:0]       pos_full;
  logic [ADDR_W-1:0] in_addr;
  logic              in_uni_ok;
  logic              in_chan_ok;

  // merge decision
  logic [LVL_W-1:0]  st_level;
  logic [PRIO_W-1:0] st_prio;
  logic              win;
  logic              do_write;
  logic              set_mark;
  logic              mark_after;
  rsp_word_t         rsp_next;

  // address of the incoming word
  always_comb begin
    pos_full   = 32'(req.universe_index) * 32'(CHANNELS_PER_UNIVERSE)
                 + 32'(req.channel_number) - 32'd1;
    in_addr    = pos_full[ADDR_W-1:0];
    in_uni_ok  = 32'(req.universe_index) < 32'(NUM_UNIVERSES);
    in_chan_ok = (req.channel_number != '0) &&
                 (32'(req.channel_number) <= 32'(CHANNELS_PER_UNIVERSE));
  end

  // capture the word on intake
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item         <= req;
      item_uni_ok  <= in_uni_ok;
      item_chan_ok <= in_chan_ok;
      item_addr    <= in_addr;
    end
  end

  // clearing pass sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  assign stat.clear_last = (clr_cnt == ADDR_W'(DEPTH - 1));

  // stored entry, level above priority
  assign st_level = ram_rdata[ENT_W-1:PRIO_W];
  assign st_prio  = ram_rdata[PRIO_W-1:0];
  assign win      = item.source_priority >= st_prio;

  // merge decision per request type
  always_comb begin
    do_write = 1'b0;
    set_mark = 1'b0;
    rsp_next = '0;
    case (item.req_type)
      REQ_SINGLE: begin
        do_write = item_uni_ok && item_chan_ok && win;
        set_mark = do_write;
      end
      REQ_FRAME: begin
        do_write = item_uni_ok && item_chan_ok && win;
        set_mark = item_uni_ok && item.frame_last;
      end
      REQ_READ: begin
        if (item_uni_ok && item_chan_ok) begin
          rsp_next.read_level    = st_level;
          rsp_next.read_priority = st_prio;
        end
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
    mark_after               = marks[item.universe_index] || set_mark;
    rsp_next.written         = do_write;
    rsp_next.universe_active = item_uni_ok && mark_after;
  end

  // table write: clearing pass or merge result
  always_comb begin
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.commit && do_write;
      ram_waddr = item_addr;
      ram_wdata = {item.level, item.source_priority};
    end
  end

  dmxpm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.load_item),
    .rd_addr (in_addr),
    .rd_data (ram_rdata)
  );

  // active marks
  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
    end else if (cmd.commit && set_mark) begin
      marks[item.universe_index] <= 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  assign stat.out_hold = rsp_valid && rsp_stall;

  // a replacing word never carries read data
  a_write_no_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.written |-> rsp.read_level == '0 && rsp.read_priority == '0)
    else $error("written response carries read data");

  // clearing pass excludes intake and commit
  a_clear_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !cmd.load_item && !cmd.commit)
    else $error("clearing overlaps item work");

  // a response that sets an active mark always reports the universe active
  a_mark_reported: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && set_mark |=> rsp.universe_active && marks[item.universe_index])
    else $error("active mark not reported");

endmodule

// ----- rtl/dmx_priority_merge_table_top.sv -----
// Priority merge table for outbound lighting channels. Each request word is
// taken when req_valid is high and req_stall low; the response word follows
// on rsp_valid/rsp_stall. After reset the table is swept to zero, one entry a
// cycle, while req_stall stays high. Afterwards the stored entry of a word is
// read from the single table ram when the word is taken; the merge then
// compares priorities, writes back and loads the response register. The next
// word is taken while a response still waits; a response that is not taken
// holds the next word in the merge, which stalls intake as well.
//
// dmx_priority_merge_table_top: top level, joins controller and datapath
// depends on dmxpm_pkg, dmxpm_ctrl, dmxpm_datapath
module dmx_priority_merge_table_top #(
  parameter int NUM_UNIVERSES         = dmxpm_pkg::NUM_UNIVERSES_DEF,
  parameter int CHANNELS_PER_UNIVERSE = dmxpm_pkg::CHANNELS_PER_UNIVERSE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  dmxpm_pkg::req_word_t req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output dmxpm_pkg::rsp_word_t rsp
);
  import dmxpm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller
  dmxpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  dmxpm_datapath #(
    .NUM_UNIVERSES         (NUM_UNIVERSES),
    .CHANNELS_PER_UNIVERSE (CHANNELS_PER_UNIVERSE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
